/* hdl/sqch_pkg.sv */
// ----------------------------------------------------------------------------
// Square channel package
// Shared widths, register indexes, state and configuration types, and the
// fixed output level table used by the square-wave channel.
// ----------------------------------------------------------------------------
package sqch_pkg;

   localparam int unsigned CLOCK_HZ = 4194304;

   // Counter units for the length, envelope and sweep timers in clocks.
   localparam int unsigned LEN_UNIT = CLOCK_HZ / 256;
   localparam int unsigned ENV_UNIT = CLOCK_HZ / 64;
   localparam int unsigned SWP_UNIT = CLOCK_HZ / 128;

   localparam int PHASE_W    = 24;
   localparam int LEN_W      = 22;
   localparam int ENV_W      = 20;
   localparam int SWP_W      = 19;
   localparam int FREQ_W     = 11;
   localparam int VOL_W      = 4;
   localparam int DUTY_W     = 5;
   localparam int LEVEL_W    = 14;
   localparam int ELAPSED_W  = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SWEEP_SHIFT    = 3'd0,
      CSR_SWEEP_SUBTRACT = 3'd1,
      CSR_SWEEP_PERIOD   = 3'd2,
      CSR_DUTY_SELECT    = 3'd3,
      CSR_LENGTH_LOAD    = 3'd4,
      CSR_LENGTH_ENABLE  = 3'd5,
      CSR_ENVELOPE       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0] sweep_shift;
      logic       sweep_subtract;
      logic [2:0] sweep_period;
      logic [1:0] duty_select;
      logic [5:0] length_load;
      logic       length_enable;
      logic [7:0] envelope_control;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0]        phase_clock;
      logic                      active;
      logic [DUTY_W-1:0]         duty_step;
      logic [LEN_W-1:0]          length_left;
      logic [ENV_W-1:0]          env_interval;
      logic [ENV_W-1:0]          env_count;
      logic [SWP_W-1:0]          sweep_interval;
      logic [SWP_W-1:0]          sweep_count;
      logic [FREQ_W-1:0]         cur_freq;
      logic [VOL_W-1:0]          volume;
      logic signed [LEVEL_W-1:0] level_out;
   } state_type;

   localparam logic [DUTY_W-1:0] DUTY_THRESH [4] = '{5'd4, 5'd8, 5'd16, 5'd24};

   // Output level for table position idx: 8191 - (16383 * idx) / 32.
   function automatic logic signed [LEVEL_W-1:0] level_at(input logic [DUTY_W-1:0] idx);
      logic [19:0] prod;
      int          lvl;
      prod = 20'(16383) * 20'(idx);
      lvl = 8191 - int'(prod >> 5);
      return LEVEL_W'(lvl);
   endfunction

endpackage

/* hdl/sqch_if.sv */
// ----------------------------------------------------------------------------
// Square channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface sqch_req_if;
   import sqch_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [ELAPSED_W-1:0] elapsed;
   logic [FREQ_W-1:0]    start_freq;

   modport source (output valid, mode, elapsed, start_freq, input ready);
   modport sink   (input valid, mode, elapsed, start_freq, output ready);
endinterface

interface sqch_rsp_if;
   import sqch_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] sample;
   logic                      channel_on;
   logic [FREQ_W-1:0]         freq_now;

   modport source (output valid, sample, channel_on, freq_now, input ready);
   modport sink   (input valid, sample, channel_on, freq_now, output ready);
endinterface

interface sqch_csr_if;
   import sqch_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sqch_update.sv */
// ----------------------------------------------------------------------------
// Square channel state update
// Next-state logic for one request: trigger load, phase step, duty level,
// length timer, frequency sweep and volume envelope.
// ----------------------------------------------------------------------------
module sqch_update (
   input  sqch_pkg::cfg_type                   cfg,
   input  sqch_pkg::state_type                 cur,
   input  logic                                mode,
   input  logic [sqch_pkg::ELAPSED_W-1:0]      elapsed,
   input  logic [sqch_pkg::FREQ_W-1:0]         start_freq,
   output sqch_pkg::state_type                 nxt
);
   import sqch_pkg::*;

   logic [PHASE_W:0]   phase_sum;
   logic [PHASE_W-1:0] phase_sat;
   logic [PHASE_W-1:0] period;
   logic [6:0]         len_steps;
   logic               run;
   logic [DUTY_W-1:0]  duty;
   logic [SWP_W-1:0]   swp_sum;
   logic [ENV_W-1:0]   env_sum;
   logic [FREQ_W-1:0]  delta;
   logic [FREQ_W:0]    new_freq;

   always_comb begin
      nxt = cur;

      phase_sum = {1'b0, cur.phase_clock} + (PHASE_W+1)'(elapsed);
      phase_sat = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
      len_steps = 7'(7'd64 - {1'b0, cfg.length_load});

      if (mode) begin
         // A trigger request zeroes the phase clock instead of adding its elapsed count.
         nxt.phase_clock    = '0;
         nxt.active         = 1'b1;
         if (cfg.length_enable) begin
            nxt.length_left = LEN_W'(len_steps) * LEN_W'(LEN_UNIT);
         end
         nxt.duty_step      = '0;
         nxt.env_interval   = ENV_W'(cfg.envelope_control[2:0]) * ENV_W'(ENV_UNIT);
         nxt.env_count      = '0;
         nxt.sweep_interval = SWP_W'(cfg.sweep_period) * SWP_W'(SWP_UNIT);
         nxt.sweep_count    = '0;
         nxt.volume         = cfg.envelope_control[7:4];
         nxt.cur_freq       = start_freq;
      end else begin
         nxt.phase_clock = phase_sat;
      end

      // The sweep and envelope still run in the request in which the length timer stops the channel, but not after it.
      run      = nxt.active;
      period   = PHASE_W'(12'(12'd2048 - {1'b0, nxt.cur_freq}));
      duty     = DUTY_W'(nxt.duty_step + 1'b1);
      swp_sum  = nxt.sweep_count + SWP_W'(elapsed);
      env_sum  = nxt.env_count + ENV_W'(elapsed);
      delta    = nxt.cur_freq >> cfg.sweep_shift;
      new_freq = cfg.sweep_subtract ? ({1'b0, nxt.cur_freq} - {1'b0, delta})
                                    : ({1'b0, nxt.cur_freq} + {1'b0, delta});

      if (run) begin
         if (nxt.phase_clock >= period) begin
            nxt.phase_clock = nxt.phase_clock - period;
            nxt.duty_step   = duty;
            if (duty > DUTY_THRESH[cfg.duty_select]) begin
               nxt.level_out = level_at(DUTY_W'(5'd16 + {1'b0, nxt.volume}));
            end else begin
               nxt.level_out = level_at(DUTY_W'(5'd16 - {1'b0, nxt.volume}));
            end
            if (cfg.length_enable) begin
               if (nxt.length_left <= LEN_W'(elapsed)) begin
                  nxt.length_left = '0;
                  nxt.active      = 1'b0;
               end else begin
                  nxt.length_left = nxt.length_left - LEN_W'(elapsed);
               end
            end
         end

         if (nxt.sweep_interval != '0) begin
            if (swp_sum >= nxt.sweep_interval) begin
               nxt.sweep_count = swp_sum - nxt.sweep_interval;
               // A result past 11 bits stops the channel and keeps the old frequency.
               if (new_freq[FREQ_W]) begin
                  nxt.active = 1'b0;
               end else begin
                  nxt.cur_freq = new_freq[FREQ_W-1:0];
               end
            end else begin
               nxt.sweep_count = swp_sum;
            end
         end

         if (nxt.env_interval != '0) begin
            if (env_sum >= nxt.env_interval) begin
               nxt.env_count = env_sum - nxt.env_interval;
               if (cfg.envelope_control[3]) begin
                  if (nxt.volume != 4'hF) begin
                     nxt.volume = nxt.volume + 1'b1;
                  end
               end else begin
                  if (nxt.volume != '0) begin
                     nxt.volume = nxt.volume - 1'b1;
                  end
               end
            end else begin
               nxt.env_count = env_sum;
            end
         end
      end
   end

endmodule

/* hdl/square_channel_with_sweep.sv */
// A request is registered in the input stage and its response in the output
// register. Throughput: one request per cycle unless responses stall; the
// state is updated combinationally from the registered request, so each
// request sees the previous result. A full response register stalls the
// request side only once the input stage also holds a request. Reset
// (synchronous) zeroes the config, state and valid flags, not data registers.
// ----------------------------------------------------------------------------
// Square channel with sweep
// Square-wave sound channel with frequency sweep, volume envelope and length
// timer, one response per tick request.
// ----------------------------------------------------------------------------
module square_channel_with_sweep (
   input logic clock,
   input logic reset,
   sqch_req_if.sink   req_chan,
   sqch_rsp_if.source rsp_chan,
   sqch_csr_if.sink   csr_chan
);
   import sqch_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in, state_next;

   logic                      in_valid_ff, in_valid_in;
   logic                      in_mode_ff;
   logic [ELAPSED_W-1:0]      in_elapsed_ff;
   logic [FREQ_W-1:0]         in_freq_ff;

   logic                      out_valid_ff, out_valid_in;
   logic signed [LEVEL_W-1:0] out_sample_ff;
   logic                      out_on_ff;
   logic [FREQ_W-1:0]         out_freq_ff;

   logic advance;
   logic req_take;
   logic do_step;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign do_step        = in_valid_ff && advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.sample     = out_sample_ff;
   assign rsp_chan.channel_on = out_on_ff;
   assign rsp_chan.freq_now   = out_freq_ff;

   sqch_update u_update (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .mode       (in_mode_ff),
      .elapsed    (in_elapsed_ff),
      .start_freq (in_freq_ff),
      .nxt        (state_next)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SWEEP_SHIFT:    cfg_in.sweep_shift      = csr_chan.data[2:0];
            CSR_SWEEP_SUBTRACT: cfg_in.sweep_subtract   = csr_chan.data[0];
            CSR_SWEEP_PERIOD:   cfg_in.sweep_period     = csr_chan.data[2:0];
            CSR_DUTY_SELECT:    cfg_in.duty_select      = csr_chan.data[1:0];
            CSR_LENGTH_LOAD:    cfg_in.length_load      = csr_chan.data[5:0];
            CSR_LENGTH_ENABLE:  cfg_in.length_enable    = csr_chan.data[0];
            CSR_ENVELOPE:       cfg_in.envelope_control = csr_chan.data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = do_step ? state_next : state_ff;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff    <= req_chan.mode;
         in_elapsed_ff <= req_chan.elapsed;
         in_freq_ff    <= req_chan.start_freq;
      end
      if (do_step) begin
         out_sample_ff <= state_next.level_out;
         out_on_ff     <= state_next.active;
         out_freq_ff   <= state_next.cur_freq;
      end
   end

   // A request held in the input stage is kept until the response side moves.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("request lost from input stage");

   a_response_made: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && advance) |=> out_valid_ff)
      else $error("processed request produced no response");

   // The sweep and envelope counters stay below their intervals whenever the interval is nonzero.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.sweep_interval != '0) |-> (state_ff.sweep_count < state_ff.sweep_interval))
      else $error("sweep count reached its interval");

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.env_interval != '0) |-> (state_ff.env_count < state_ff.env_interval))
      else $error("envelope count reached its interval");

endmodule
